// ===== design/ssd_pkg.sv =====
// shared types for the segment span diagonal block
// sequencer state encoding and the control/status bundle of the square root unit
// no dependencies
package ssd_pkg;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SPAN = 6'b000010,
        S_SQ_V = 6'b000100,
        S_SQ_T = 6'b001000,
        S_ADD  = 6'b010000,
        S_ROOT = 6'b100000
    } t_state;

    // square root unit control
    typedef struct packed {
        logic start;
    } t_sqrt_ctl;

    // square root unit status
    typedef struct packed {
        logic busy;
    } t_sqrt_stat;

endpackage

// ===== design/ssd_bounds.sv =====
// bounding box tracker: running value min/max, earliest begin and latest end time
// gives the value span and the absolute time span of the current box
// depends on nothing outside this file
module ssd_bounds #(
    parameter int VALUE_BITS = 24,
    parameter int TIME_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic signed [VALUE_BITS-1:0] i_value_begin,
    input  logic signed [VALUE_BITS-1:0] i_value_end,
    input  logic        [TIME_BITS-1:0]  i_time_begin,
    input  logic        [TIME_BITS-1:0]  i_time_end,
    input  logic                         i_last_segment,
    output logic        [VALUE_BITS-1:0] o_value_span,
    output logic        [TIME_BITS-1:0]  o_time_span
);

    logic signed [VALUE_BITS-1:0] r_vmin, n_vmin;
    logic signed [VALUE_BITS-1:0] r_vmax, n_vmax;
    logic        [TIME_BITS-1:0]  r_tmin, n_tmin;
    logic        [TIME_BITS-1:0]  r_tmax, n_tmax;
    logic                         r_open, n_open;

    logic signed [VALUE_BITS-1:0] w_vlo, w_vhi;
    logic signed [VALUE_BITS:0]   w_vdiff;

    // order the two endpoint values of the item
    assign w_vlo = (i_value_begin < i_value_end) ? i_value_begin : i_value_end;
    assign w_vhi = (i_value_begin < i_value_end) ? i_value_end : i_value_begin;

    // box update: a new group loads from the item, an open group widens
    always_comb begin
        n_vmin = r_vmin;
        n_vmax = r_vmax;
        n_tmin = r_tmin;
        n_tmax = r_tmax;
        n_open = r_open;
        if (i_accept) begin
            if (!r_open) begin
                n_vmin = w_vlo;
                n_vmax = w_vhi;
                n_tmin = i_time_begin;
                n_tmax = i_time_end;
            end else begin
                n_vmin = (w_vlo < r_vmin) ? w_vlo : r_vmin;
                n_vmax = (w_vhi > r_vmax) ? w_vhi : r_vmax;
                n_tmin = (i_time_begin < r_tmin) ? i_time_begin : r_tmin;
                n_tmax = (i_time_end > r_tmax) ? i_time_end : r_tmax;
            end
            n_open = !i_last_segment;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin <= '0;
            r_vmax <= '0;
            r_tmin <= '0;
            r_tmax <= '0;
            r_open <= 1'b0;
        end else begin
            r_vmin <= n_vmin;
            r_vmax <= n_vmax;
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            r_open <= n_open;
        end
    end

    // spans of the box, the value span always fits unsigned in VALUE_BITS
    assign w_vdiff      = {r_vmax[VALUE_BITS-1], r_vmax} - {r_vmin[VALUE_BITS-1], r_vmin};
    assign o_value_span = w_vdiff[VALUE_BITS-1:0];
    assign o_time_span  = (r_tmax >= r_tmin) ? (r_tmax - r_tmin) : (r_tmin - r_tmax);

endmodule

// ===== design/ssd_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
// once busy drops after start, the floor root is held on o_root
// depends on ssd_pkg for the control and status bundles
module ssd_sqrt
    import ssd_pkg::*;
#(
    parameter int ROOT_BITS = 25
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_sqrt_ctl                i_ctl,
    input  logic [2*ROOT_BITS-1:0]   i_radicand,
    output t_sqrt_stat               o_stat,
    output logic [ROOT_BITS-1:0]     o_root
);

    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic [2*ROOT_BITS-1:0] r_rad, n_rad;
    logic [ROOT_BITS+1:0]   r_rem, n_rem;
    logic [ROOT_BITS-1:0]   r_root, n_root;
    logic [CNT_BITS-1:0]    r_count, n_count;

    logic [ROOT_BITS+3:0]   w_shift;
    logic [ROOT_BITS+3:0]   w_trial;
    logic [ROOT_BITS+3:0]   w_diff;
    logic                   w_fit;

    // one restoring step: bring down two bits, try (4*root + 1)
    assign w_shift = {r_rem, r_rad[2*ROOT_BITS-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_fit   = (w_shift >= w_trial);
    assign w_diff  = w_shift - w_trial;

    always_comb begin
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_count = r_count;
        if (i_ctl.start) begin
            n_rad   = i_radicand;
            n_rem   = '0;
            n_root  = '0;
            n_count = CNT_BITS'(ROOT_BITS);
        end else if (r_count != '0) begin
            n_rad   = {r_rad[2*ROOT_BITS-3:0], 2'b00};
            n_rem   = w_fit ? w_diff[ROOT_BITS+1:0] : w_shift[ROOT_BITS+1:0];
            n_root  = {r_root[ROOT_BITS-2:0], w_fit};
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // datapath registers carry no reset
    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_stat.busy = (r_count != '0);
    assign o_root      = r_root;

endmodule

// ===== design/segment_span_diagonal_unit.sv =====
// segment span diagonal: bounding box of a group of segments, then its diagonal
// an item that does not close a group is taken without stalling; a closing item stalls the
// input until its result is emitted: the spans are captured, squared in turn by one shared
// squaring multiplier and summed, then rooted by the two-bits-per-cycle square root unit;
// the result is registered into the output slot once the root is done and the slot is free
// synchronous active-low reset clears the box to zero with no group open
module segment_span_diagonal_unit
    import ssd_pkg::*;
#(
    parameter  int VALUE_BITS = 24,
    parameter  int TIME_BITS  = 24,
    localparam int DIAG_BITS  = ((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [VALUE_BITS-1:0] i_value_begin,
    input  logic signed [VALUE_BITS-1:0] i_value_end,
    input  logic        [TIME_BITS-1:0]  i_time_begin,
    input  logic        [TIME_BITS-1:0]  i_time_end,
    input  logic                         i_last_segment,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic        [DIAG_BITS-1:0]  o_diagonal_length
);

    localparam int MUL_BITS = DIAG_BITS - 1;
    localparam int SUM_BITS = 2 * DIAG_BITS;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_dv;
    logic [TIME_BITS-1:0]    r_dt;
    logic [2*MUL_BITS-1:0]   r_prod;
    logic [SUM_BITS-1:0]     r_sum;
    logic                    r_out_valid;
    logic [DIAG_BITS-1:0]    r_out_data;

    logic                    w_in_accept;
    logic                    w_out_free;
    logic                    w_emit;
    logic [VALUE_BITS-1:0]   w_value_span;
    logic [TIME_BITS-1:0]    w_time_span;
    logic [MUL_BITS-1:0]     w_mul_op;
    logic [2*MUL_BITS-1:0]   w_prod;
    logic [SUM_BITS-1:0]     w_radicand;
    logic [DIAG_BITS-1:0]    w_root;
    t_sqrt_ctl               w_sqrt_ctl;
    t_sqrt_stat              w_sqrt_stat;

    // input handshake: items are taken only while idle
    assign o_stall     = (r_state != S_IDLE);
    assign w_in_accept = i_valid && (r_state == S_IDLE);

    // output slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_emit     = (r_state == S_ROOT) && !w_sqrt_stat.busy && w_out_free;

    ssd_bounds #(
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_bounds (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_accept),
        .i_value_begin  (i_value_begin),
        .i_value_end    (i_value_end),
        .i_time_begin   (i_time_begin),
        .i_time_end     (i_time_end),
        .i_last_segment (i_last_segment),
        .o_value_span   (w_value_span),
        .o_time_span    (w_time_span)
    );

    // sequencer
    always_comb begin
        n_state          = r_state;
        w_sqrt_ctl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept && i_last_segment) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                n_state = S_SQ_V;
            end
            S_SQ_V: begin
                n_state = S_SQ_T;
            end
            S_SQ_T: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                w_sqrt_ctl.start = 1'b1;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared squaring multiplier: value span first, then time span
    assign w_mul_op   = (r_state == S_SQ_V) ? MUL_BITS'(r_dv) : MUL_BITS'(r_dt);
    assign w_prod     = w_mul_op * w_mul_op;
    assign w_radicand = r_sum + SUM_BITS'(r_prod);

    // span capture, squares and partial sum
    always_ff @(posedge i_clk) begin
        if (r_state == S_SPAN) begin
            r_dv <= w_value_span;
            r_dt <= w_time_span;
        end
        if ((r_state == S_SQ_V) || (r_state == S_SQ_T)) begin
            r_prod <= w_prod;
        end
        if (r_state == S_SQ_T) begin
            r_sum <= SUM_BITS'(r_prod);
        end
    end

    ssd_sqrt #(
        .ROOT_BITS (DIAG_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_sqrt_ctl),
        .i_radicand (w_radicand),
        .o_stat     (w_sqrt_stat),
        .o_root     (w_root)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_root;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_diagonal_length = r_out_data;

endmodule
